// File: src/mtg_pkg.sv
// Shared types, constants and helper functions of the MT19937 generator.
package mtg_pkg;

  // State store geometry and twist offset
  localparam int unsigned DEPTH  = 624;
  localparam int unsigned OFFSET = 397;
  localparam int unsigned IDX_W  = 10;

  typedef logic [31:0]      word_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Recurrence and tempering constants
  localparam word_t TWIST_MATRIX = 32'h9908_B0DF;
  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t TEMPER_B     = 32'h9D2C_5680;
  localparam word_t TEMPER_C     = 32'hEFC6_0000;
  localparam word_t TOP_BIT      = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7FFF_FFFF;

  localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);
  localparam idx_t FULL_POS = idx_t'(DEPTH);

  // Request codes
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED_START,
    OP_SEED_MUL,
    OP_SEED_WR,
    OP_TW_PRIME,
    OP_TW_FIRST,
    OP_TW_READ,
    OP_TW_WRITE,
    OP_DRAW_RD,
    OP_DRAW_OUT
  } op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic pos_full;
    logic idx_last;
    logic out_free;
  } status_t;

  // Index of the following word, wrapping at the end of the store
  function automatic idx_t next_idx(idx_t i);
    idx_t r;
    if (i == LAST_IDX) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  // Index of the word OFFSET places on, modulo DEPTH
  function automatic idx_t far_idx(idx_t i);
    logic [IDX_W:0] s;
    s = {1'b0, i} + (IDX_W+1)'(OFFSET);
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // One twist step: join top bit of upper with low bits of lower, then mix
  function automatic word_t twist_mix(word_t upper, word_t lower);
    word_t joined;
    word_t mixed;
    joined = (upper & TOP_BIT) | (lower & LOW_BITS);
    mixed  = joined >> 1;
    if (joined[0]) begin
      mixed = mixed ^ TWIST_MATRIX;
    end
    return mixed;
  endfunction

  // Four shift-and-xor tempering steps, the middle two also masked
  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: src/mtg_if.sv
// Valid/ready channel interfaces for request and random word beats.
interface mtg_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] seed;

  modport source (output valid, output req_type, output seed, input ready);
  modport sink   (input valid, input req_type, input seed, output ready);
endinterface

interface mtg_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// File: src/mtg_datapath.sv
// Datapath: state store, seeding multiplier, twist unit, tempering and output register.
module mtg_datapath (
  input  logic             clk,
  input  logic             rst,
  input  mtg_pkg::op_t     op,
  input  mtg_pkg::word_t   seed,
  input  logic             out_ready,
  output mtg_pkg::status_t status,
  output logic             out_valid,
  output mtg_pkg::word_t   out_word
);

  mtg_pkg::word_t mem [mtg_pkg::DEPTH];

  mtg_pkg::word_t rd0;
  mtg_pkg::word_t rd1;
  mtg_pkg::word_t cur;
  mtg_pkg::word_t prev;
  mtg_pkg::word_t prod;
  mtg_pkg::idx_t  idx;
  mtg_pkg::idx_t  pos;
  logic           seeded;

  logic           we;
  mtg_pkg::idx_t  waddr;
  mtg_pkg::word_t wdata;
  mtg_pkg::idx_t  raddr0;
  mtg_pkg::idx_t  raddr1;
  mtg_pkg::word_t seed_val;
  mtg_pkg::word_t twist_val;
  mtg_pkg::word_t spread;
  logic           out_free;

  // Per-word arithmetic
  assign spread    = prev ^ (prev >> 30);
  assign seed_val  = prod + {22'd0, idx};
  assign twist_val = rd1 ^ mtg_pkg::twist_mix(cur, rd0);
  assign out_free  = !out_valid || out_ready;

  assign status.pos_full = (pos >= mtg_pkg::FULL_POS);
  assign status.idx_last = (idx == mtg_pkg::LAST_IDX);
  assign status.out_free = out_free;

  // Store addressing per operation
  always_comb begin
    we     = 1'b0;
    waddr  = idx;
    wdata  = twist_val;
    raddr0 = pos;
    raddr1 = mtg_pkg::far_idx(idx);
    case (op)
      mtg_pkg::OP_SEED_START: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed;
      end
      mtg_pkg::OP_SEED_WR: begin
        we    = 1'b1;
        wdata = seed_val;
      end
      mtg_pkg::OP_TW_PRIME: begin
        raddr0 = '0;
      end
      mtg_pkg::OP_TW_FIRST, mtg_pkg::OP_TW_READ: begin
        raddr0 = mtg_pkg::next_idx(idx);
      end
      mtg_pkg::OP_TW_WRITE: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[raddr0];
    rd1 <= mem[raddr1];
  end

  // Working registers without reset
  always_ff @(posedge clk) begin
    case (op)
      mtg_pkg::OP_SEED_START: prev <= seed;
      mtg_pkg::OP_SEED_MUL:   prod <= spread * mtg_pkg::SEED_MULT;
      mtg_pkg::OP_SEED_WR:    prev <= seed_val;
      mtg_pkg::OP_TW_FIRST:   cur  <= rd0;
      mtg_pkg::OP_TW_WRITE:   cur  <= rd0;
      default: begin
      end
    endcase
    if (op == mtg_pkg::OP_DRAW_OUT && out_free) begin
      out_word <= seeded ? mtg_pkg::temper(rd0) : '0;
    end
  end

  // Counters, seeded flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      pos       <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        mtg_pkg::OP_SEED_START: begin
          idx    <= mtg_pkg::idx_t'(1);
          pos    <= mtg_pkg::FULL_POS;
          seeded <= 1'b1;
        end
        mtg_pkg::OP_SEED_WR: begin
          idx <= idx + mtg_pkg::idx_t'(1);
        end
        mtg_pkg::OP_TW_PRIME: begin
          idx <= '0;
        end
        mtg_pkg::OP_TW_WRITE: begin
          idx <= idx + mtg_pkg::idx_t'(1);
          if (idx == mtg_pkg::LAST_IDX) begin
            pos <= '0;
          end
        end
        mtg_pkg::OP_DRAW_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (seeded) begin
              pos <= pos + mtg_pkg::idx_t'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= mtg_pkg::FULL_POS)
    else $error("position ran past the store");

  a_unseeded_pos: assert property (@(posedge clk) disable iff (rst)
    !seeded |-> pos == '0)
    else $error("position moved before first reseed");

  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    (op == mtg_pkg::OP_DRAW_OUT && out_free && !seeded) |=> out_word == '0)
    else $error("non-zero word from an unseeded store");

  a_twist_end: assert property (@(posedge clk) disable iff (rst)
    (op == mtg_pkg::OP_TW_WRITE && idx == mtg_pkg::LAST_IDX) |=> pos == '0)
    else $error("twist did not rewind the position");

  a_seed_start: assert property (@(posedge clk) disable iff (rst)
    op == mtg_pkg::OP_SEED_START |=> (seeded && pos == mtg_pkg::FULL_POS))
    else $error("reseed did not mark the store full");

endmodule

// File: src/mtg_controller.sv
// Controller: sequences reseed fills, full twists and draws over the datapath.
module mtg_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_req_type,
  input  mtg_pkg::status_t status,
  output logic             in_ready,
  output mtg_pkg::op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_WR,
    S_TW_PRIME,
    S_TW_FIRST,
    S_TW_READ,
    S_TW_WRITE,
    S_DRAW_RD,
    S_DRAW_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Operation decode
  always_comb begin
    case (state)
      S_IDLE: begin
        op = (accept && in_req_type == mtg_pkg::REQ_RESEED) ? mtg_pkg::OP_SEED_START
                                                           : mtg_pkg::OP_NONE;
      end
      S_SEED_MUL: op = mtg_pkg::OP_SEED_MUL;
      S_SEED_WR:  op = mtg_pkg::OP_SEED_WR;
      S_TW_PRIME: op = mtg_pkg::OP_TW_PRIME;
      S_TW_FIRST: op = mtg_pkg::OP_TW_FIRST;
      S_TW_READ:  op = mtg_pkg::OP_TW_READ;
      S_TW_WRITE: op = mtg_pkg::OP_TW_WRITE;
      S_DRAW_RD:  op = mtg_pkg::OP_DRAW_RD;
      S_DRAW_OUT: op = mtg_pkg::OP_DRAW_OUT;
      default:    op = mtg_pkg::OP_NONE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type == mtg_pkg::REQ_RESEED) begin
              state <= S_SEED_MUL;
            end else if (status.pos_full) begin
              state <= S_TW_PRIME;
            end else begin
              state <= S_DRAW_RD;
            end
          end
        end
        S_SEED_MUL: state <= S_SEED_WR;
        S_SEED_WR: begin
          state <= status.idx_last ? S_IDLE : S_SEED_MUL;
        end
        S_TW_PRIME: state <= S_TW_FIRST;
        S_TW_FIRST: state <= S_TW_WRITE;
        S_TW_READ:  state <= S_TW_WRITE;
        S_TW_WRITE: begin
          state <= status.idx_last ? S_DRAW_RD : S_TW_READ;
        end
        S_DRAW_RD:  state <= S_DRAW_OUT;
        S_DRAW_OUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_draw_no_twist: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAW_RD |-> !status.pos_full)
    else $error("draw read with the store exhausted");

  a_twist_order: assert property (@(posedge clk) disable iff (rst)
    state == S_TW_WRITE |-> ($past(state) == S_TW_FIRST || $past(state) == S_TW_READ))
    else $error("twist write without its reads");

  a_seed_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_SEED_MUL |=> state == S_SEED_WR)
    else $error("seed product not written back");

endmodule

// File: src/mersenne_twister_generator_top.sv
// Draw: a read state, then an output state registering the tempered word as result beat
// once the output register is free; no new request is taken till then. With all 624 words
// used up, a draw first runs a full twist: each word's neighbour and far word are read, then
// it is written through the single write port. Reseed: the seed is word 0, then one product
// and one write per further word; no result. Reset: synchronous; position 0 and a seeded
// flag cleared, so the store reads as all zeros until the first reseed; no clearing pass.
module mersenne_twister_generator_top (
  input  logic       clk,
  input  logic       rst,
  mtg_req_if.sink    req,
  mtg_word_if.source rsp
);

  mtg_pkg::op_t     op;
  mtg_pkg::status_t status;

  mtg_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .status      (status),
    .in_ready    (req.ready),
    .op          (op)
  );

  mtg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .seed      (req.seed),
    .out_ready (rsp.ready),
    .status    (status),
    .out_valid (rsp.valid),
    .out_word  (rsp.random_word)
  );

endmodule
